### design/cat_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the column activity crop tracker.
package cat_pkg;

   localparam int ROW_WIDTH_W = 11;
   localparam int ALPHA_W     = 16;
   localparam int THRESH_W    = 24;
   localparam int PERIOD_W    = 8;
   localparam int AVG_W       = 24;
   localparam int PIX_W       = 8;
   localparam int LUM_W       = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int LEFT_W      = 10;
   localparam int RIGHT_W     = 11;

   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;
   localparam logic [ALPHA_W-1:0]     ALPHA_RESET     = 16'd5243;
   localparam logic [THRESH_W-1:0]    THRESH_RESET    = 24'd196608;
   localparam logic [PERIOD_W-1:0]    PERIOD_RESET    = 8'd16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD    = 2'd3;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_CLEAR = 1'b1
   } cat_op_type;

   typedef struct packed {
      cat_op_type       op;
      logic [PIX_W-1:0] pixel_red;
      logic [PIX_W-1:0] pixel_green;
      logic [PIX_W-1:0] pixel_blue;
   } cat_req_type;

   typedef struct packed {
      logic [LEFT_W-1:0]  crop_left;
      logic [RIGHT_W-1:0] crop_right;
      logic               recomputed;
   } cat_rsp_type;

endpackage

### design/cat_avg_ram.sv
`timescale 1ns / 1ps
// Column average memory: one write port, one registered read port.
module cat_avg_ram #(
   parameter int DEPTH  = 1024,
   parameter int IDX_W  = 10,
   parameter int DATA_W = 24
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/cat_ema.sv
`timescale 1ns / 1ps
// Luminance capture and exponential average update for one column.
module cat_ema (
   input  logic                             clock,
   input  logic                             load,
   input  cat_pkg::cat_req_type             pixel,
   input  logic [cat_pkg::ALPHA_W-1:0]      alpha,
   input  logic [cat_pkg::AVG_W-1:0]        avg,
   output logic [cat_pkg::AVG_W-1:0]        new_avg
);

   logic [12:0]                 lum_sum;
   logic [cat_pkg::LUM_W-1:0]   lum_ff;
   logic [cat_pkg::LUM_W-1:0]   lum_in;
   logic signed [24:0]          diff;
   logic signed [41:0]          prod;

   always_comb begin
      lum_sum = 13'(pixel.pixel_red) * 13'd11 + 13'(pixel.pixel_green) * 13'd16
              + 13'(pixel.pixel_blue) * 13'd5;
      lum_in  = load ? lum_sum[12:5] : lum_ff;
   end

   always_ff @(posedge clock) begin
      lum_ff <= lum_in;
   end

   always_comb begin
      diff    = $signed({1'b0, lum_ff, 16'b0}) - $signed({1'b0, avg});
      prod    = $signed({1'b0, alpha}) * diff;
      new_avg = avg + prod[39:16];
   end

endmodule

### design/column_activity_crop_tracker_unit.sv
`timescale 1ns / 1ps
// Column activity crop tracker top level: control, registers and result stage.
// A pixel reads its column average when accepted, then updates and writes it back in ST_UPDATE.
// At a row end the result is loaded in ST_EMIT; a recompute first runs a left scan, a right scan
// down from the row end and a crop step (ST_LSCAN, ST_RSCAN, ST_CROP).
// Reset, a clear transfer and a change of the clamped row width each start a clearing pass
// over all MAX_WIDTH entries of the average memory, during which no input transfer is taken.
module column_activity_crop_tracker_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  cat_pkg::cat_req_type                 req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cat_pkg::cat_rsp_type                 rsp_payload,
   input  logic                                 csr_wr_en,
   input  logic [cat_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cat_pkg::CSR_DATA_W-1:0]       csr_wr_data
);

   localparam int IDX_W   = $clog2(MAX_WIDTH);
   localparam int CNT_W   = $clog2(MAX_WIDTH + 1);
   localparam int EW      = (CNT_W > cat_pkg::ROW_WIDTH_W) ? CNT_W : cat_pkg::ROW_WIDTH_W;
   localparam int RESET_W = (MAX_WIDTH < cat_pkg::ROW_WIDTH_RESET) ? MAX_WIDTH
                                                                   : cat_pkg::ROW_WIDTH_RESET;

   typedef enum logic [6:0] {
      ST_SWEEP  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_UPDATE = 7'b0000100,
      ST_LSCAN  = 7'b0001000,
      ST_RSCAN  = 7'b0010000,
      ST_CROP   = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   function automatic logic [CNT_W-1:0] clamp_width(
      input logic [cat_pkg::ROW_WIDTH_W-1:0] rw
   );
      logic [EW-1:0]    ext;
      logic [CNT_W-1:0] res;
      ext = EW'(rw);
      if (ext == '0) begin
         res = CNT_W'(1);
      end else if (ext > EW'(MAX_WIDTH)) begin
         res = CNT_W'(MAX_WIDTH);
      end else begin
         res = CNT_W'(ext);
      end
      return res;
   endfunction

   function automatic logic [CNT_W-1:0] pos_inc(input logic [CNT_W-1:0] pos);
      return pos + CNT_W'(1);
   endfunction

   state_type                         state_ff, state_in;
   logic [cat_pkg::ROW_WIDTH_W-1:0]   row_width_ff, row_width_in;
   logic [cat_pkg::ALPHA_W-1:0]       alpha_ff, alpha_in;
   logic [cat_pkg::THRESH_W-1:0]      thresh_ff, thresh_in;
   logic [cat_pkg::PERIOD_W-1:0]      period_ff, period_in;
   logic [CNT_W-1:0]                  column_pos_ff, column_pos_in;
   logic [cat_pkg::PERIOD_W-1:0]      rows_ff, rows_in;
   logic [CNT_W-1:0]                  left_edge_ff, left_edge_in;
   logic [CNT_W-1:0]                  right_edge_ff, right_edge_in;
   logic [IDX_W-1:0]                  sweep_ff, sweep_in;
   logic                              pend_ff, pend_in;
   logic [CNT_W-1:0]                  scan_pos_ff, scan_pos_in;
   logic [CNT_W-1:0]                  rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]                  found_left_ff, found_left_in;
   logic [CNT_W-1:0]                  found_right_ff, found_right_in;
   logic                              recomp_ff, recomp_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   cat_pkg::cat_rsp_type              rsp_payload_ff, rsp_payload_in;

   logic [CNT_W-1:0]                  eff_width;
   logic [CNT_W-1:0]                  new_width;
   logic [CNT_W-1:0]                  pos_next;
   logic [CNT_W-1:0]                  scan_dec;
   logic [CNT_W-1:0]                  span;
   logic [cat_pkg::PERIOD_W-1:0]      rows_next;
   logic [cat_pkg::PERIOD_W-1:0]      period_eff;
   logic                              hit;
   logic                              req_accept;

   logic                              mem_wr_en;
   logic [IDX_W-1:0]                  mem_wr_addr;
   logic [cat_pkg::AVG_W-1:0]         mem_wr_data;
   logic [IDX_W-1:0]                  mem_rd_addr;
   logic [cat_pkg::AVG_W-1:0]         mem_rd_data;
   logic [cat_pkg::AVG_W-1:0]         new_avg;

   cat_avg_ram #(
      .DEPTH  (MAX_WIDTH),
      .IDX_W  (IDX_W),
      .DATA_W (cat_pkg::AVG_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   cat_ema u_ema (
      .clock   (clock),
      .load    (req_accept),
      .pixel   (req_payload),
      .alpha   (alpha_ff),
      .avg     (mem_rd_data),
      .new_avg (new_avg)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_accept  = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      eff_width  = clamp_width(row_width_ff);
      new_width  = clamp_width(csr_wr_data[cat_pkg::ROW_WIDTH_W-1:0]);
      pos_next   = column_pos_ff + CNT_W'(1);
      scan_dec   = scan_pos_ff - CNT_W'(1);
      span       = found_right_ff - found_left_ff;
      rows_next  = rows_ff + cat_pkg::PERIOD_W'(1);
      period_eff = (period_ff == '0) ? cat_pkg::PERIOD_W'(1) : period_ff;
      hit        = pend_ff && (mem_rd_data >= thresh_ff);
   end

   always_comb begin
      state_in       = state_ff;
      row_width_in   = row_width_ff;
      alpha_in       = alpha_ff;
      thresh_in      = thresh_ff;
      period_in      = period_ff;
      column_pos_in  = column_pos_ff;
      rows_in        = rows_ff;
      left_edge_in   = left_edge_ff;
      right_edge_in  = right_edge_ff;
      sweep_in       = sweep_ff;
      pend_in        = pend_ff;
      scan_pos_in    = scan_pos_ff;
      rd_addr_in     = rd_addr_ff;
      found_left_in  = found_left_ff;
      found_right_in = found_right_ff;
      recomp_in      = recomp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = column_pos_ff[IDX_W-1:0];
      mem_wr_data    = new_avg;
      mem_rd_addr    = column_pos_ff[IDX_W-1:0];

      case (state_ff)
         ST_SWEEP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff;
            mem_wr_data = '0;
            if (sweep_ff == IDX_W'(MAX_WIDTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.op == cat_pkg::OP_CLEAR) begin
                  left_edge_in  = '0;
                  right_edge_in = eff_width;
                  sweep_in      = '0;
                  state_in      = ST_SWEEP;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            mem_wr_en = 1'b1;
            if (pos_next < eff_width) begin
               column_pos_in = pos_next;
               state_in      = ST_IDLE;
            end else begin
               column_pos_in = '0;
               if (rows_next >= period_eff) begin
                  rows_in     = '0;
                  scan_pos_in = '0;
                  pend_in     = 1'b0;
                  state_in    = ST_LSCAN;
               end else begin
                  rows_in   = rows_next;
                  recomp_in = 1'b0;
                  state_in  = ST_EMIT;
               end
            end
         end
         ST_LSCAN: begin
            mem_rd_addr = scan_pos_ff[IDX_W-1:0];
            if (hit) begin
               found_left_in = rd_addr_ff;
               scan_pos_in   = eff_width;
               pend_in       = 1'b0;
               state_in      = ST_RSCAN;
            end else if (scan_pos_ff == eff_width) begin
               found_left_in  = eff_width;
               found_right_in = eff_width;
               state_in       = ST_CROP;
            end else begin
               rd_addr_in  = scan_pos_ff;
               pend_in     = 1'b1;
               scan_pos_in = pos_inc(scan_pos_ff);
            end
         end
         ST_RSCAN: begin
            mem_rd_addr = scan_dec[IDX_W-1:0];
            if (hit) begin
               found_right_in = rd_addr_ff + CNT_W'(1);
               state_in       = ST_CROP;
            end else if (scan_pos_ff == found_left_ff) begin
               found_right_in = found_left_ff;
               state_in       = ST_CROP;
            end else begin
               rd_addr_in  = scan_dec;
               pend_in     = 1'b1;
               scan_pos_in = scan_dec;
            end
         end
         ST_CROP: begin
            if (span < (eff_width >> 3)) begin
               left_edge_in  = '0;
               right_edge_in = eff_width;
            end else begin
               left_edge_in  = found_left_ff;
               right_edge_in = found_right_ff;
            end
            recomp_in = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.crop_left  = cat_pkg::LEFT_W'(left_edge_ff);
               rsp_payload_in.crop_right = cat_pkg::RIGHT_W'(right_edge_ff);
               rsp_payload_in.recomputed = recomp_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         case (csr_index)
            cat_pkg::CSR_ROW_WIDTH: begin
               row_width_in = csr_wr_data[cat_pkg::ROW_WIDTH_W-1:0];
               if (new_width != eff_width) begin
                  left_edge_in  = '0;
                  right_edge_in = new_width;
                  column_pos_in = '0;
                  sweep_in      = '0;
                  state_in      = ST_SWEEP;
               end
            end
            cat_pkg::CSR_ALPHA: begin
               alpha_in = csr_wr_data[cat_pkg::ALPHA_W-1:0];
            end
            cat_pkg::CSR_THRESHOLD: begin
               thresh_in = csr_wr_data[cat_pkg::THRESH_W-1:0];
            end
            cat_pkg::CSR_PERIOD: begin
               period_in = csr_wr_data[cat_pkg::PERIOD_W-1:0];
            end
            default: begin
               row_width_in = row_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         row_width_ff  <= cat_pkg::ROW_WIDTH_RESET;
         alpha_ff      <= cat_pkg::ALPHA_RESET;
         thresh_ff     <= cat_pkg::THRESH_RESET;
         period_ff     <= cat_pkg::PERIOD_RESET;
         column_pos_ff <= '0;
         rows_ff       <= '0;
         left_edge_ff  <= '0;
         right_edge_ff <= CNT_W'(RESET_W);
         sweep_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_width_ff  <= row_width_in;
         alpha_ff      <= alpha_in;
         thresh_ff     <= thresh_in;
         period_ff     <= period_in;
         column_pos_ff <= column_pos_in;
         rows_ff       <= rows_in;
         left_edge_ff  <= left_edge_in;
         right_edge_ff <= right_edge_in;
         sweep_ff      <= sweep_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_pos_ff    <= scan_pos_in;
      rd_addr_ff     <= rd_addr_in;
      found_left_ff  <= found_left_in;
      found_right_ff <= found_right_in;
      recomp_ff      <= recomp_in;
      rsp_payload_ff <= rsp_payload_in;
   end

`ifndef NO_ASSERTIONS
   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LSCAN || state_ff == ST_RSCAN) |-> !mem_wr_en)
      else $error("average memory written during edge scan");

   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_payload.op == cat_pkg::OP_CLEAR && !csr_wr_en)
      |=> (state_ff == ST_SWEEP && left_edge_ff == '0 && right_edge_ff == eff_width))
      else $error("clear transfer did not reset crop and start sweep");

   a_pos_in_row: assert property (@(posedge clock) disable iff (reset)
      column_pos_ff < eff_width)
      else $error("column position beyond row width");

   a_edges_ordered: assert property (@(posedge clock) disable iff (reset)
      left_edge_ff <= right_edge_ff && right_edge_ff <= eff_width)
      else $error("crop edges out of order");
`endif

endmodule

### tb/column_activity_crop_tracker_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the column activity crop tracker: directed and random rows.
module column_activity_crop_tracker_unit_tb;

   localparam int MAX_COLS = 1024;
   localparam int SETTLE_CYCLES = 2400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   cat_pkg::cat_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   cat_pkg::cat_rsp_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [cat_pkg::CSR_INDEX_W-1:0] csr_index = cat_pkg::CSR_ROW_WIDTH;
   logic [cat_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   logic [cat_pkg::ROW_WIDTH_W-1:0] width_cfg;
   logic [cat_pkg::ALPHA_W-1:0] alpha_cfg;
   logic [cat_pkg::THRESH_W-1:0] thresh_cfg;
   logic [cat_pkg::PERIOD_W-1:0] period_cfg;
   logic [cat_pkg::AVG_W-1:0] avg_mirror [0:MAX_COLS-1];
   logic [cat_pkg::LEFT_W-1:0] col_next;
   logic [cat_pkg::PERIOD_W-1:0] row_count;
   logic [cat_pkg::LEFT_W-1:0] left_mirror;
   logic [cat_pkg::RIGHT_W-1:0] right_mirror;

   cat_pkg::cat_rsp_type crop_expected [$];
   int unsigned mismatch_count = 0;
   int unsigned burst_left = 0;
   logic sender_gaps_on = 1'b0;
   logic rsp_stalls_on = 1'b0;
   int unsigned rsp_hold_left = 0;

   column_activity_crop_tracker_unit #(.MAX_WIDTH(MAX_COLS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned active_width();
      int unsigned w;
      w = width_cfg;
      if (w < 1) w = 1;
      if (w > MAX_COLS) w = MAX_COLS;
      return w;
   endfunction

   function automatic void clear_columns();
      foreach (avg_mirror[i]) avg_mirror[i] = '0;
      left_mirror = '0;
      right_mirror = cat_pkg::RIGHT_W'(active_width());
   endfunction

   function automatic void rescan_crop();
      int unsigned w;
      int unsigned l;
      int unsigned r;
      w = active_width();
      l = 0;
      while (l < w && avg_mirror[l] < thresh_cfg) l++;
      r = w;
      while (r > l && avg_mirror[r-1] < thresh_cfg) r--;
      if (r - l < w / 8) begin
         left_mirror = '0;
         right_mirror = cat_pkg::RIGHT_W'(w);
      end else begin
         left_mirror = cat_pkg::LEFT_W'(l);
         right_mirror = cat_pkg::RIGHT_W'(r);
      end
   endfunction

   function automatic void advance_tracker(input cat_pkg::cat_req_type item);
      int unsigned w;
      int unsigned col;
      int unsigned period;
      int lum;
      longint avg_now;
      longint alpha_now;
      longint diff;
      longint delta;
      logic hit;
      cat_pkg::cat_rsp_type res;
      w = active_width();
      if (item.op == cat_pkg::OP_CLEAR) begin
         clear_columns();
         return;
      end
      lum = (11 * int'(item.pixel_red) + 16 * int'(item.pixel_green)
             + 5 * int'(item.pixel_blue)) >> 5;
      col = col_next;
      avg_now = avg_mirror[col];
      alpha_now = alpha_cfg;
      diff = longint'(lum) * 65536 - avg_now;
      delta = (alpha_now * diff) >>> 16;
      avg_mirror[col] = cat_pkg::AVG_W'(avg_now + delta);
      if (col + 1 < w) begin
         col_next = col_next + 1'b1;
         return;
      end
      col_next = '0;
      period = (period_cfg == 0) ? 1 : period_cfg;
      row_count = row_count + 1'b1;
      hit = 1'b0;
      if (row_count >= period) begin
         row_count = '0;
         rescan_crop();
         hit = 1'b1;
      end
      res.crop_left = left_mirror;
      res.crop_right = right_mirror;
      res.recomputed = hit;
      crop_expected.push_back(res);
   endfunction

   function automatic void apply_csr(input logic [cat_pkg::CSR_INDEX_W-1:0] index,
                                     input logic [cat_pkg::CSR_DATA_W-1:0] data);
      int unsigned old_w;
      old_w = active_width();
      case (index)
         cat_pkg::CSR_ROW_WIDTH: begin
            width_cfg = data[cat_pkg::ROW_WIDTH_W-1:0];
            if (active_width() != old_w) begin
               clear_columns();
               col_next = '0;
            end
         end
         cat_pkg::CSR_ALPHA: alpha_cfg = data[cat_pkg::ALPHA_W-1:0];
         cat_pkg::CSR_THRESHOLD: thresh_cfg = data[cat_pkg::THRESH_W-1:0];
         cat_pkg::CSR_PERIOD: period_cfg = data[cat_pkg::PERIOD_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void note_failure(input string what, input int unsigned want,
                                        input int unsigned got);
      if (mismatch_count < 10)
         $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
   endfunction

   function automatic cat_pkg::cat_req_type make_item(input cat_pkg::cat_op_type op,
                                                      input logic [cat_pkg::PIX_W-1:0] red,
                                                      input logic [cat_pkg::PIX_W-1:0] green,
                                                      input logic [cat_pkg::PIX_W-1:0] blue);
      cat_pkg::cat_req_type item;
      item.op = op;
      item.pixel_red = red;
      item.pixel_green = green;
      item.pixel_blue = blue;
      return item;
   endfunction

   // bright pixels inside [lo, hi), dark outside, with some noise and clears
   function automatic cat_pkg::cat_req_type scene_pixel(input int unsigned lo,
                                                        input int unsigned hi,
                                                        input int unsigned clear_pct,
                                                        input int unsigned noise_pct);
      int unsigned pick;
      int unsigned col;
      cat_pkg::cat_req_type item;
      pick = $urandom_range(0, 99);
      col = col_next;
      item = make_item(cat_pkg::OP_PIXEL, cat_pkg::PIX_W'($urandom()),
                       cat_pkg::PIX_W'($urandom()), cat_pkg::PIX_W'($urandom()));
      if (pick < clear_pct) begin
         item.op = cat_pkg::OP_CLEAR;
      end else if (pick >= clear_pct + noise_pct) begin
         if (col >= lo && col < hi) begin
            item.pixel_red = cat_pkg::PIX_W'($urandom_range(150, 255));
            item.pixel_green = cat_pkg::PIX_W'($urandom_range(150, 255));
            item.pixel_blue = cat_pkg::PIX_W'($urandom_range(150, 255));
         end else begin
            item.pixel_red = cat_pkg::PIX_W'($urandom_range(0, 40));
            item.pixel_green = cat_pkg::PIX_W'($urandom_range(0, 40));
            item.pixel_blue = cat_pkg::PIX_W'($urandom_range(0, 40));
         end
      end
      return item;
   endfunction

   task automatic send_item(input cat_pkg::cat_req_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = sender_gaps_on ? $urandom_range(1, 10) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_payload <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      advance_tracker(item);
   endtask

   task automatic await_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (crop_expected.size() != 0);
   endtask

   task automatic settle_block();
      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [cat_pkg::CSR_INDEX_W-1:0] index,
                            input logic [cat_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= data;
      @(posedge clock);
      apply_csr(index, data);
   endtask

   task automatic program_tracker(input logic [cat_pkg::CSR_DATA_W-1:0] width_data,
                                  input logic [cat_pkg::CSR_DATA_W-1:0] alpha_data,
                                  input logic [cat_pkg::CSR_DATA_W-1:0] thresh_data,
                                  input logic [cat_pkg::CSR_DATA_W-1:0] period_data);
      settle_block();
      csr_write(cat_pkg::CSR_ROW_WIDTH, width_data);
      csr_write(cat_pkg::CSR_ALPHA, alpha_data);
      csr_write(cat_pkg::CSR_THRESHOLD, thresh_data);
      csr_write(cat_pkg::CSR_PERIOD, period_data);
      csr_wr_en <= 1'b0;
   endtask

   // width 0 clamps to one column, period 0 acts as 1: every pixel ends a row
   task automatic test_single_column_rows();
      program_tracker(24'd0, 24'hFFFFFF, 24'd0, 24'hFFFF00);
      sender_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      send_item(make_item(cat_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00));
      send_item(make_item(cat_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF));
      send_item(make_item(cat_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'h00));
      send_item(make_item(cat_pkg::OP_PIXEL, 8'h00, 8'hFF, 8'h00));
      send_item(make_item(cat_pkg::OP_PIXEL, 8'h00, 8'h00, 8'hFF));
      send_item(make_item(cat_pkg::OP_CLEAR, 8'hFF, 8'h00, 8'hA5));
      send_item(make_item(cat_pkg::OP_PIXEL, 8'h80, 8'h80, 8'h80));
   endtask

   // widths above the maximum clamp; an equal effective width keeps the row
   task automatic test_width_clamp();
      program_tracker(24'd2047, cat_pkg::CSR_DATA_W'(cat_pkg::ALPHA_RESET), 24'hFFFFFF,
                      cat_pkg::CSR_DATA_W'(cat_pkg::PERIOD_RESET));
      sender_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      send_item(make_item(cat_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF));
      send_item(make_item(cat_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00));
      send_item(make_item(cat_pkg::OP_PIXEL, 8'hAA, 8'h55, 8'hAA));
      send_item(make_item(cat_pkg::OP_PIXEL, 8'h55, 8'hAA, 8'h55));
      program_tracker(24'hFFFC00, cat_pkg::CSR_DATA_W'(cat_pkg::ALPHA_RESET), 24'hFFFFFF,
                      cat_pkg::CSR_DATA_W'(cat_pkg::PERIOD_RESET));
      send_item(make_item(cat_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF));
      send_item(make_item(cat_pkg::OP_PIXEL, 8'h01, 8'h80, 8'hFE));
   endtask

   // no column reaches the top threshold, so the crop falls back to full width
   task automatic test_empty_crop_fallback();
      program_tracker(24'd8, 24'hFFFFFF, 24'hFFFFFF, 24'd1);
      repeat (8) send_item(scene_pixel(0, 8, 0, 100));
   endtask

   // hold the result side off while the sender keeps offering one-column rows
   task automatic test_result_backpressure();
      program_tracker(24'd1, cat_pkg::CSR_DATA_W'($urandom_range(0, 65535)),
                      cat_pkg::CSR_DATA_W'($urandom_range(0, 255 << 16)), 24'd255);
      sender_gaps_on = 1'b0;
      rsp_stalls_on = 1'b1;
      rsp_hold_left = 400;
      repeat (260) send_item(scene_pixel(0, 1, 0, 30));
   endtask

   task automatic test_random_scenes(input int unsigned phases);
      logic [cat_pkg::CSR_DATA_W-1:0] width_data;
      logic [cat_pkg::CSR_DATA_W-1:0] alpha_data;
      logic [cat_pkg::CSR_DATA_W-1:0] thresh_data;
      logic [cat_pkg::CSR_DATA_W-1:0] period_data;
      int unsigned items;
      int unsigned lo;
      int unsigned hi;
      int unsigned w;
      logic pause;
      for (int unsigned p = 0; p < phases; p++) begin
         case ($urandom_range(0, 7))
            0: width_data = 24'd0;
            1: width_data = 24'd1;
            2: width_data = 24'd8;
            3: width_data = 24'd16;
            4: width_data = cat_pkg::CSR_DATA_W'($urandom_range(49, 64));
            default: width_data = cat_pkg::CSR_DATA_W'($urandom_range(2, 24));
         endcase
         if ($urandom_range(0, 1) != 0)
            width_data[cat_pkg::CSR_DATA_W-1:cat_pkg::ROW_WIDTH_W] =
               (cat_pkg::CSR_DATA_W-cat_pkg::ROW_WIDTH_W)'($urandom());
         case ($urandom_range(0, 5))
            0: alpha_data = 24'd0;
            1: alpha_data = 24'hFFFFFF;
            2: alpha_data = cat_pkg::CSR_DATA_W'(cat_pkg::ALPHA_RESET);
            default: alpha_data = cat_pkg::CSR_DATA_W'($urandom());
         endcase
         case ($urandom_range(0, 5))
            0: thresh_data = 24'd0;
            1: thresh_data = 24'hFFFFFF;
            default: thresh_data = cat_pkg::CSR_DATA_W'($urandom_range(1, 60 << 16));
         endcase
         case ($urandom_range(0, 4))
            0: period_data = cat_pkg::CSR_DATA_W'($urandom()) & 24'hFFFF00;
            1: period_data = 24'd1;
            default: period_data = cat_pkg::CSR_DATA_W'($urandom_range(2, 6));
         endcase
         program_tracker(width_data, alpha_data, thresh_data, period_data);
         w = active_width();
         lo = $urandom_range(0, w - 1);
         hi = $urandom_range(lo, w);
         items = $urandom_range(30, 80) + 4 * w;
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         pause = (p == 0) || ($urandom_range(0, 1) != 0);
         for (int unsigned n = 0; n < items; n++) begin
            if (pause && n == items / 2) await_results();
            send_item(scene_pixel(lo, hi, 3, 10));
         end
      end
   endtask

   initial begin : rsp_side
      logic ready_phase;
      int unsigned run_left;
      ready_phase = 1'b1;
      run_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left != 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else if (!rsp_stalls_on) begin
            rsp_ready <= 1'b1;
         end else begin
            if (run_left == 0) begin
               ready_phase = !ready_phase;
               run_left = ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 8);
            end
            run_left--;
            rsp_ready <= ready_phase;
         end
      end
   end

   always @(posedge clock) begin : check_results
      cat_pkg::cat_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (crop_expected.size() == 0) begin
            note_failure("result transfer with nothing pending", 0, rsp_payload);
         end else begin
            want = crop_expected.pop_front();
            if (rsp_payload.crop_left !== want.crop_left)
               note_failure("crop_left", want.crop_left, rsp_payload.crop_left);
            if (rsp_payload.crop_right !== want.crop_right)
               note_failure("crop_right", want.crop_right, rsp_payload.crop_right);
            if (rsp_payload.recomputed !== want.recomputed)
               note_failure("recomputed", want.recomputed, rsp_payload.recomputed);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      width_cfg = cat_pkg::ROW_WIDTH_RESET;
      alpha_cfg = cat_pkg::ALPHA_RESET;
      thresh_cfg = cat_pkg::THRESH_RESET;
      period_cfg = cat_pkg::PERIOD_RESET;
      col_next = '0;
      row_count = '0;
      clear_columns();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_single_column_rows();
      test_width_clamp();
      test_empty_crop_fallback();
      test_result_backpressure();
      test_random_scenes(9);
      settle_block();
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
